@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation and status codes, and the access descriptor passed from
// the pointer control to the storage and the result path.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Port widths fixed by the interface.
	localparam int OP_W   = 3;
	localparam int POS_W  = 4;
	localparam int WORD_W = 32;
	localparam int OCC_W  = 5;
	localparam int STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic             wr_en;
		logic [PTR_W-1:0] slot;
		logic             use_word;
		logic             use_rd;
		status_t          status;
	} deq_access_t;

endpackage

@@ rtl/deq_store.sv @@
// ----------------------------------------------------------------------------
// Deque storage
// Register file of DEPTH words with one write port and one read port that
// share the slot address chosen by the pointer control.
// ----------------------------------------------------------------------------
module deq_store (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [deq_pkg::PTR_W-1:0]    slot,
	input  logic [deq_pkg::DATA_WIDTH-1:0] wr_data,
	output logic [deq_pkg::DATA_WIDTH-1:0] rd_data
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// Entries carry no reset: every slot below the count was written by a push.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[slot] <= wr_data;
		end
	end

	assign rd_data = mem_q[slot];

endmodule

@@ rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Deque pointer control
// Holds the front pointer and element count, decodes one operation, picks
// the storage slot and the status, and updates its state on each transfer.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [deq_pkg::OP_W-1:0]  op,
	input  logic [deq_pkg::POS_W-1:0] pos,
	output deq_pkg::deq_access_t      acc,
	output logic [deq_pkg::CNT_W-1:0] count
);
	import deq_pkg::*;

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);

	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	logic [PTR_W-1:0] front_dec;
	logic [PTR_W-1:0] front_inc;
	logic [CNT_W-1:0] offset;
	logic [PTR_W:0]   sum;
	logic [PTR_W-1:0] wrapped;
	logic             empty;
	logic             full;
	logic             in_range;

	assign empty     = (count_q == '0);
	assign full      = (count_q >= DEPTH_C);
	assign in_range  = (CNT_W'(pos) < count_q);
	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - PTR_W'(1);
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + PTR_W'(1);

	// Offset from the front: the back end for a push back, the last element for
	// a pop back, the requested position otherwise. It is always below DEPTH when
	// it is used, so one conditional subtract wraps the sum.
	always_comb begin
		unique case (op)
			OP_PUSH_BACK: offset = count_q;
			OP_POP_BACK:  offset = count_q - CNT_W'(1);
			default:      offset = CNT_W'(pos);
		endcase
	end

	assign sum     = {1'b0, front_q} + (PTR_W + 1)'(offset);
	assign wrapped = (sum >= DEPTH_X) ? PTR_W'(sum - DEPTH_X) : PTR_W'(sum);

	always_comb begin
		acc          = '0;
		acc.status   = ST_OK;
		acc.slot     = wrapped;
		front_d      = front_q;
		count_d      = count_q;
		unique case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					acc.status = ST_FULL;
				end else begin
					acc.wr_en    = 1'b1;
					acc.use_word = 1'b1;
					count_d      = count_q + CNT_W'(1);
					if (op == OP_PUSH_FRONT) begin
						acc.slot = front_dec;
						front_d  = front_dec;
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					acc.status = ST_EMPTY;
				end else begin
					acc.use_rd = 1'b1;
					count_d    = count_q - CNT_W'(1);
					if (op == OP_POP_FRONT) begin
						acc.slot = front_q;
						front_d  = front_inc;
					end
				end
			end
			OP_READ, OP_WRITE: begin
				if (!in_range) begin
					acc.status = ST_RANGE;
				end else begin
					acc.use_rd = 1'b1;
					acc.wr_en  = (op == OP_WRITE);
				end
			end
			default: begin
				// Unused codes leave everything as it is.
			end
		endcase
		acc.wr_en = acc.wr_en & advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	assign count = count_d;

endmodule

@@ rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of data words in a circular buffer, one operation per item.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel (in_valid, in_ready) carries an opcode,
// a position and a data word. It performs one of push front, push back, pop
// front, pop back, read at a position or overwrite at a position, and gives
// exactly one result on the output channel (out_valid, out_ready): the data
// word, the occupancy after the operation and a status code. Operations that
// cannot be done are flagged in status and change nothing.
// Path: an item taken on the input channel sits in the input register, is
// executed against the queue state and lands in the result register when it
// moves on, from where the output channel shows its result.
// Throughput: one item per cycle while the receiver does not stall, set by the
// single pass through the pointer adder and the register-file read between
// the two registers. Reset clears the front pointer, the count and both valid
// flags; the data storage is not cleared. While the receiver stalls, the result
// register holds, the item in the input register waits and in_ready falls.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [deq_pkg::OP_W-1:0]   opcode,
	input  logic [deq_pkg::POS_W-1:0]  position,
	input  logic [deq_pkg::WORD_W-1:0] data_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [deq_pkg::WORD_W-1:0] data_out,
	output logic [deq_pkg::OCC_W-1:0]  occupancy,
	output logic [deq_pkg::STAT_W-1:0] status
);
	import deq_pkg::*;

	logic                  valid_s1;
	logic [OP_W-1:0]       op_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [DATA_WIDTH-1:0] word_s1;

	logic                  valid_s2;
	logic [WORD_W-1:0]     data_s2;
	logic [OCC_W-1:0]      occ_s2;
	status_t               status_s2;

	logic                  advance;
	deq_access_t           acc;
	logic [CNT_W-1:0]      count;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [DATA_WIDTH-1:0] result;

	// The held item moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= opcode;
			pos_s1  <= position;
			word_s1 <= DATA_WIDTH'(data_in);
		end
	end

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.op      (op_s1),
		.pos     (pos_s1),
		.acc     (acc),
		.count   (count)
	);

	deq_store u_store (
		.clk     (clk),
		.wr_en   (acc.wr_en),
		.slot    (acc.slot),
		.wr_data (word_s1),
		.rd_data (rd_data)
	);

	always_comb begin
		if (acc.use_word) begin
			result = word_s1;
		end else if (acc.use_rd) begin
			result = rd_data;
		end else begin
			result = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2   <= WORD_W'(result);
			occ_s2    <= OCC_W'(count);
			status_s2 <= acc.status;
		end
	end

	assign out_valid = valid_s2;
	assign data_out  = data_s2;
	assign occupancy = occ_s2;
	assign status    = status_s2;

endmodule

@@ tb/sv/double_ended_queue_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, read and write operations through the input channel,
// predicts every result with a shadow copy of the queue and compares each
// result transfer field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

	import deq_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
	localparam int DIRECTED_DRAIN_AT = 700;
	localparam int CALM_TAIL         = 150;
	localparam int HOLD_AFTER        = 300;
	localparam int HOLD_CYCLES       = 60;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
		bit                wait_empty;
	} deque_op_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [OCC_W-1:0]  fill;
		logic [STAT_W-1:0] code;
	} deque_result_t;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} plan_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] opcode = '0;
	logic [POS_W-1:0] position = '0;
	logic [WORD_W-1:0] data_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WORD_W-1:0] data_out;
	logic [OCC_W-1:0] occupancy;
	logic [STAT_W-1:0] status;

	// Shadow copy of the queue used to work out each result.
	logic [WORD_W-1:0] shadow_mem [DEPTH];
	logic [PTR_W-1:0] shadow_head = '0;
	logic [OCC_W-1:0] shadow_fill = '0;

	deque_op_t queued_ops [$];
	deque_result_t awaited_results [$];
	int plan_fill = 0;
	int planned_total = 0;
	int error_count = 0;
	int results_seen = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	logic calm = 1'b0;

	double_ended_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.position  (position),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.occupancy (occupancy),
		.status    (status)
	);

	always #5 clk = ~clk;

	function automatic deque_result_t deque_apply(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word);
		deque_result_t r;
		logic [PTR_W-1:0] slot;
		r.word = '0;
		r.code = ST_OK;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (shadow_fill == OCC_W'(DEPTH)) begin
					r.code = ST_FULL;
				end else begin
					if (op == OP_PUSH_FRONT) begin
						shadow_head = shadow_head - 1'b1;
						slot = shadow_head;
					end else begin
						slot = shadow_head + PTR_W'(shadow_fill);
					end
					shadow_mem[slot] = word;
					shadow_fill = shadow_fill + 1'b1;
					r.word = word;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (shadow_fill == '0) begin
					r.code = ST_EMPTY;
				end else begin
					if (op == OP_POP_FRONT) begin
						r.word = shadow_mem[shadow_head];
						shadow_head = shadow_head + 1'b1;
					end else begin
						r.word = shadow_mem[shadow_head + PTR_W'(shadow_fill - 1'b1)];
					end
					shadow_fill = shadow_fill - 1'b1;
				end
			end
			OP_READ, OP_WRITE: begin
				if (OCC_W'(pos) >= shadow_fill) begin
					r.code = ST_RANGE;
				end else begin
					slot = shadow_head + PTR_W'(pos);
					r.word = shadow_mem[slot];
					if (op == OP_WRITE)
						shadow_mem[slot] = word;
				end
			end
			default: ;
		endcase
		r.fill = shadow_fill;
		return r;
	endfunction

	// Queues one operation; the planner keeps its own count so that the random
	// part can steer towards a full or an empty queue.
	task automatic plan_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] word);
		deque_op_t item;
		item.op = op;
		item.pos = pos;
		item.word = word;
		item.wait_empty = (planned_total == DIRECTED_DRAIN_AT);
		queued_ops.push_back(item);
		planned_total++;
		if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && plan_fill < DEPTH)
			plan_fill++;
		else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && plan_fill > 0)
			plan_fill--;
	endtask

	// Sender: offers the next queued operation unless a gap is running or it must
	// wait for all results first, and holds the offer steady until its transfer.
	always @(posedge clk) begin : drive
		logic busy;
		logic go;
		deque_op_t nxt;
		if (arst_n) begin
			busy = in_valid;
			go = 1'b0;
			if (in_valid && in_ready) begin
				awaited_results.push_back(deque_apply(opcode, position, data_in));
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (queued_ops.size() != 0 &&
						!(queued_ops[0].wait_empty && awaited_results.size() != 0)) begin
					if (!calm && $urandom_range(0, 7) == 0)
						send_gap <= $urandom_range(0, 10);
					else
						go = 1'b1;
				end
			end
			if (go) begin
				nxt = queued_ops.pop_front();
				opcode <= nxt.op;
				position <= nxt.pos;
				data_in <= nxt.word;
			end
			in_valid <= busy || go;
			calm <= (queued_ops.size() < CALM_TAIL);
		end
	end

	// Receiver: checks each result transfer and stalls in random bursts.
	always @(posedge clk) begin : observe
		deque_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (awaited_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("result with none pending: data %h occupancy %0d status %0d",
							data_out, occupancy, status);
				end else begin
					want = awaited_results.pop_front();
					if (data_out !== want.word || occupancy !== want.fill ||
							status !== want.code) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch: expected data %h occupancy %0d status %0d, %s",
								want.word, want.fill, want.code,
								$sformatf("got data %h occupancy %0d status %0d",
									data_out, occupancy, status));
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One long hold-off on the result side so that the block backs up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	initial begin : run
		int real_items;
		int mode_left;
		int pick;
		plan_mode_t mode;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;
		real_items = 0;
		mode_left = 0;
		mode = MODE_FILL;

		// Empty queue: both pops, out-of-range read and write, unused opcodes.
		plan_op(OP_POP_FRONT, 4'd0, 32'h0);
		plan_op(OP_POP_BACK, 4'd15, 32'hFFFF_FFFF);
		plan_op(OP_READ, 4'd0, 32'h0);
		plan_op(OP_WRITE, 4'd15, 32'hFFFF_FFFF);
		plan_op(OP_SPARE_A, 4'd0, 32'hFFFF_FFFF);
		plan_op(OP_SPARE_B, 4'd15, 32'h0);
		// Pushes at both ends with extreme words.
		plan_op(OP_PUSH_BACK, 4'd0, 32'h0000_0000);
		plan_op(OP_PUSH_FRONT, 4'd15, 32'hFFFF_FFFF);
		plan_op(OP_PUSH_BACK, 4'd0, 32'hA5A5_A5A5);
		plan_op(OP_PUSH_FRONT, 4'd0, 32'h5A5A_5A5A);
		plan_op(OP_PUSH_BACK, 4'd0, 32'h8000_0001);
		for (int i = 0; i < 6; i++)
			plan_op(OP_READ, POS_W'(i), 32'h0);
		plan_op(OP_WRITE, 4'd2, 32'h1234_5678);
		plan_op(OP_READ, 4'd2, 32'h0);
		plan_op(OP_WRITE, 4'd15, 32'hDEAD_BEEF);
		// Drain from both ends, one pop too many.
		plan_op(OP_POP_BACK, 4'd0, 32'h0);
		plan_op(OP_POP_FRONT, 4'd0, 32'h0);
		plan_op(OP_POP_FRONT, 4'd0, 32'h0);
		plan_op(OP_POP_BACK, 4'd0, 32'h0);
		plan_op(OP_POP_BACK, 4'd0, 32'h0);
		plan_op(OP_POP_FRONT, 4'd0, 32'h0);

		// Random part in runs that lean towards filling, draining or neither,
		// so that the full and empty cases keep coming round.
		while (real_items < 1350) begin
			if (mode_left == 0) begin
				mode = plan_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 40);
			end
			mode_left--;
			pick = $urandom_range(0, 99);
			if (plan_fill != 0 && $urandom_range(0, 3) != 0)
				pos = POS_W'($urandom_range(0, plan_fill - 1));
			else
				pos = POS_W'($urandom_range(0, 15));
			if (pick < 2)
				op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
			else if (mode == MODE_MIXED)
				op = OP_W'($urandom_range(OP_PUSH_FRONT, OP_WRITE));
			else if (pick < 60)
				op = (mode == MODE_FILL) ?
					($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK) :
					($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK);
			else if (pick < 72)
				op = (mode == MODE_FILL) ?
					($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK) :
					($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
			else if (pick < 86)
				op = OP_READ;
			else
				op = OP_WRITE;
			plan_op(op, pos, $urandom);
			if (op != OP_SPARE_A && op != OP_SPARE_B)
				real_items++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (queued_ops.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (8) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("double_ended_queue_test: done, clean");
		else
			$display("double_ended_queue_test: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("double_ended_queue_test: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/deq_pkg.sv
rtl/deq_store.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
